### rtl/udp_ipv4_frame_builder_unit_assert.svh
// Assertion macros used by the frame builder checker.
`ifndef UDP_IPV4_FRAME_BUILDER_UNIT_ASSERT_SVH
`define UDP_IPV4_FRAME_BUILDER_UNIT_ASSERT_SVH

// Clocked assertion that is switched off while reset is asserted.
`define UDPFB_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

`endif

### rtl/udpfb_pkg.sv
// Types and constants of the UDP/IPv4 frame builder.
`default_nettype none

package udpfb_pkg;

  localparam int MaxPayloadDef = 1472;
  localparam int HdrBytes      = 42;
  localparam int IdxW          = $clog2(HdrBytes);

  localparam logic [15:0] EphFirst      = 16'd49152;
  localparam logic [15:0] EphLast       = 16'd65500;
  localparam logic [15:0] IdentReset    = 16'd1;
  localparam logic [7:0]  IpVerIhl      = 8'h45;
  localparam logic [7:0]  IpTtl         = 8'd64;
  localparam logic [7:0]  IpProtoUdp    = 8'd17;
  localparam logic [15:0] EtherTypeIpv4 = 16'h0800;
  localparam logic [15:0] IpLenBase     = 16'd28;
  localparam logic [15:0] UdpLenBase    = 16'd8;

  localparam logic OpHeader  = 1'b0;
  localparam logic OpPayload = 1'b1;

  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 48;
  localparam logic [CfgIdxW-1:0] RegSourceMac = 1'b0;
  localparam logic [CfgIdxW-1:0] RegSourceIp  = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [31:0] dest_ip;
    logic [15:0] dest_port;
    logic [15:0] local_port;
    logic [15:0] payload_length;
    logic [7:0]  payload_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  frame_byte;
    logic        frame_last;
    logic [15:0] port_used;
  } out_item_t;

  // Per-frame header fields captured when a header beat is taken.
  typedef struct packed {
    logic [31:0] dest_ip;
    logic [15:0] dest_port;
    logic [15:0] src_port;
    logic [15:0] ip_len;
    logic [15:0] udp_len;
    logic [15:0] ident;
  } hdr_ctx_t;

endpackage

`default_nettype wire

### rtl/udpfb_hdr.sv
// Header context, pipelined IPv4 checksum and header byte selection.
`default_nettype none

module udpfb_hdr (
  input  logic                      clk_i,
  input  logic                      load_i,
  input  udpfb_pkg::hdr_ctx_t       ctx_i,
  input  logic [47:0]               source_mac_i,
  input  logic [31:0]               source_ip_i,
  input  logic [udpfb_pkg::IdxW-1:0] idx_i,
  output logic [7:0]                byte_o
);

  udpfb_pkg::hdr_ctx_t ctx_q;
  logic [17:0] sum_a_q, sum_b_q;
  logic [18:0] sum_q;
  logic [16:0] fold1;
  logic [15:0] fold2;
  logic [15:0] ck_q;
  logic [7:0]  hb [udpfb_pkg::HdrBytes];

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ctx_q <= ctx_i;
    end
  end

  // The checksum runs freely off the held context through sum_a_q/sum_b_q, sum_q
  // and ck_q, and settles long before the checksum bytes are reached on the wire.
  assign fold1 = 17'(sum_q[15:0]) + 17'(sum_q[18:16]);
  assign fold2 = fold1[15:0] + 16'(fold1[16]);

  always_ff @(posedge clk_i) begin
    sum_a_q <= 18'({udpfb_pkg::IpVerIhl, 8'h00}) + 18'({udpfb_pkg::IpTtl, udpfb_pkg::IpProtoUdp})
             + 18'(ctx_q.ip_len) + 18'(ctx_q.ident);
    sum_b_q <= 18'(source_ip_i[31:16]) + 18'(source_ip_i[15:0])
             + 18'(ctx_q.dest_ip[31:16]) + 18'(ctx_q.dest_ip[15:0]);
    sum_q   <= 19'(sum_a_q) + 19'(sum_b_q);
    ck_q    <= ~fold2;
  end

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      hb[i]     = 8'hFF;
      hb[6 + i] = source_mac_i[8*(5-i) +: 8];
    end
    hb[12] = udpfb_pkg::EtherTypeIpv4[15:8];
    hb[13] = udpfb_pkg::EtherTypeIpv4[7:0];
    hb[14] = udpfb_pkg::IpVerIhl;
    hb[15] = 8'h00;
    hb[16] = ctx_q.ip_len[15:8];
    hb[17] = ctx_q.ip_len[7:0];
    hb[18] = ctx_q.ident[15:8];
    hb[19] = ctx_q.ident[7:0];
    hb[20] = 8'h00;
    hb[21] = 8'h00;
    hb[22] = udpfb_pkg::IpTtl;
    hb[23] = udpfb_pkg::IpProtoUdp;
    hb[24] = ck_q[15:8];
    hb[25] = ck_q[7:0];
    for (int i = 0; i < 4; i++) begin
      hb[26 + i] = source_ip_i[8*(3-i) +: 8];
      hb[30 + i] = ctx_q.dest_ip[8*(3-i) +: 8];
    end
    hb[34] = ctx_q.src_port[15:8];
    hb[35] = ctx_q.src_port[7:0];
    hb[36] = ctx_q.dest_port[15:8];
    hb[37] = ctx_q.dest_port[7:0];
    hb[38] = ctx_q.udp_len[15:8];
    hb[39] = ctx_q.udp_len[7:0];
    hb[40] = 8'h00;
    hb[41] = 8'h00;
  end

  assign byte_o = (32'(idx_i) < udpfb_pkg::HdrBytes) ? hb[idx_i] : 8'h00;

endmodule

`default_nettype wire

### rtl/udp_ipv4_frame_builder_unit.sv
// Top level of the UDP/IPv4 Ethernet frame builder.
//
//   channel | direction | handshake              | beat
//   --------+-----------+------------------------+------------------------------
//   in      | sink      | in_valid_i / in_stall_o | header item or payload byte
//   out     | source    | out_valid_o/out_stall_i | one frame byte with last, port
//   cfg     | sink      | cfg_we_i               | source MAC or source IP
//
// Payload beats stream back to back while the output is not stalled.
// A header beat emits 42 header bytes, one header byte per cycle while the output
// is not stalled; the input is stalled until the last of them enters the output register.
// The output register holds a beat while out_stall_i is high; the input is
// stalled only while that register cannot take a new beat or a header runs.
// Reset is asynchronous and clears all control state and the config registers.
`default_nettype none

module udp_ipv4_frame_builder_unit #(
  parameter int MaxPayload = udpfb_pkg::MaxPayloadDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  udpfb_pkg::in_item_t               in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output udpfb_pkg::out_item_t              out_data_o,
  input  logic                              cfg_we_i,
  input  logic [udpfb_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [udpfb_pkg::CfgDataW-1:0]    cfg_data_i
);

  localparam int RemW = $clog2(MaxPayload + 1);

  logic [47:0] mac_q;
  logic [31:0] sip_q;

  logic [15:0] ident_q, ident_d;
  logic [15:0] eph_q, eph_d;
  logic [RemW-1:0] rem_q, rem_d;
  logic [15:0] frame_port_q, frame_port_d;
  logic hdr_active_q, hdr_active_d;
  logic [udpfb_pkg::IdxW-1:0] hdr_idx_q, hdr_idx_d;
  logic out_valid_q, out_valid_d;
  udpfb_pkg::out_item_t out_q, out_d;

  logic out_ready, in_acc, hdr_start, pay_acc, hdr_last;
  logic [RemW-1:0] plen_cap;
  logic [15:0] lport_sel, eph_nx;
  logic [16:0] eph_inc;
  logic [7:0] hdr_byte;
  udpfb_pkg::hdr_ctx_t ctx;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign in_stall_o = hdr_active_q || !out_ready;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign hdr_start  = in_acc && (in_data_i.opcode == udpfb_pkg::OpHeader);
  assign pay_acc    = in_acc && (in_data_i.opcode == udpfb_pkg::OpPayload) && (rem_q != '0);
  assign hdr_last   = (hdr_idx_q == udpfb_pkg::IdxW'(udpfb_pkg::HdrBytes - 1));

  assign plen_cap = (in_data_i.payload_length > 16'(MaxPayload)) ? RemW'(MaxPayload)
                                                                 : in_data_i.payload_length[RemW-1:0];
  assign lport_sel = (in_data_i.local_port == 16'd0) ? eph_q : in_data_i.local_port;
  assign eph_inc   = 17'(eph_q) + 17'd1;
  assign eph_nx    = (eph_inc > 17'(udpfb_pkg::EphLast)) ? udpfb_pkg::EphFirst : eph_inc[15:0];

  always_comb begin
    ctx.dest_ip   = in_data_i.dest_ip;
    ctx.dest_port = in_data_i.dest_port;
    ctx.src_port  = lport_sel;
    ctx.ip_len    = udpfb_pkg::IpLenBase + 16'(plen_cap);
    ctx.udp_len   = udpfb_pkg::UdpLenBase + 16'(plen_cap);
    ctx.ident     = ident_q;
  end

  udpfb_hdr u_hdr (
    .clk_i        (clk_i),
    .load_i       (hdr_start),
    .ctx_i        (ctx),
    .source_mac_i (mac_q),
    .source_ip_i  (sip_q),
    .idx_i        (hdr_idx_q),
    .byte_o       (hdr_byte)
  );

  always_comb begin
    ident_d      = ident_q;
    eph_d        = eph_q;
    rem_d        = rem_q;
    frame_port_d = frame_port_q;
    hdr_active_d = hdr_active_q;
    hdr_idx_d    = hdr_idx_q;
    out_valid_d  = out_valid_q;
    out_d        = out_q;

    if (out_ready) begin
      out_valid_d = 1'b0;
    end

    if (hdr_active_q && out_ready) begin
      out_valid_d      = 1'b1;
      out_d.frame_byte = hdr_byte;
      out_d.frame_last = hdr_last && (rem_q == '0);
      out_d.port_used  = frame_port_q;
      hdr_idx_d        = hdr_idx_q + 1'b1;
      if (hdr_last) begin
        hdr_active_d = 1'b0;
      end
    end else if (pay_acc) begin
      out_valid_d      = 1'b1;
      out_d.frame_byte = in_data_i.payload_byte;
      out_d.frame_last = (rem_q == RemW'(1));
      out_d.port_used  = frame_port_q;
      rem_d            = rem_q - 1'b1;
    end

    // A header beat restarts the frame and drops what was left of the old one.
    if (hdr_start) begin
      hdr_active_d = 1'b1;
      hdr_idx_d    = '0;
      rem_d        = plen_cap;
      frame_port_d = lport_sel;
      ident_d      = ident_q + 16'd1;
      if (in_data_i.local_port == 16'd0) begin
        eph_d = eph_nx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ident_q      <= udpfb_pkg::IdentReset;
      eph_q        <= udpfb_pkg::EphFirst;
      rem_q        <= '0;
      frame_port_q <= '0;
      hdr_active_q <= 1'b0;
      hdr_idx_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      ident_q      <= ident_d;
      eph_q        <= eph_d;
      rem_q        <= rem_d;
      frame_port_q <= frame_port_d;
      hdr_active_q <= hdr_active_d;
      hdr_idx_q    <= hdr_idx_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mac_q <= '0;
      sip_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        udpfb_pkg::RegSourceMac: mac_q <= cfg_data_i[47:0];
        udpfb_pkg::RegSourceIp:  sip_q <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

### rtl/udpfb_checker.sv
// Port-level checker for the frame builder and its bind statement.
`default_nettype none

`include "udp_ipv4_frame_builder_unit_assert.svh"

module udpfb_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input udpfb_pkg::in_item_t  in_data_i,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input udpfb_pkg::out_item_t out_data_o
);

  logic hdr_beat;

  assign hdr_beat = in_valid_i && !in_stall_o && (in_data_i.opcode == udpfb_pkg::OpHeader);

  `UDPFB_ASSERT(a_out_valid_held, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o, "output beat dropped while stalled")
  `UDPFB_ASSERT(a_out_data_held, clk_i, rst_ni, out_valid_o && out_stall_i |=> $stable(out_data_o), "output beat changed while stalled")
  `UDPFB_ASSERT(a_hdr_blocks_input, clk_i, rst_ni, hdr_beat |=> in_stall_o, "input not stalled while header is sent")
  `UDPFB_ASSERT(a_hdr_first_byte, clk_i, rst_ni, hdr_beat |-> ##2 (out_valid_o && out_data_o.frame_byte == 8'hFF && !out_data_o.frame_last), "frame does not open with broadcast byte")

endmodule

bind udp_ipv4_frame_builder_unit udpfb_checker u_udpfb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
